[rtl/core/fkw_pkg.sv]
// Shared types, constants and command/status structs for the random-walk trial block.
// No dependencies; every other file refers to this package by scoped names.
package fkw_pkg;

   localparam int NUM_POINTS  = 11;
   localparam int MAX_STEPS   = 1048576;
   localparam int STEP_W      = $clog2(MAX_STEPS + 1);
   localparam int ACC_DEPTH   = NUM_POINTS + 1;
   localparam int ACC_IDX_W   = $clog2(ACC_DEPTH);

   localparam int PI_W        = 4;
   localparam int XIN_W       = 32;
   localparam int T_W         = 31;
   localparam int A_W         = 31;
   localparam int H_W         = 32;
   localparam int STEPSZ_W    = 31;
   localparam int N_W         = 21;
   localparam int WGT_W       = 32;
   localparam int TOT_W       = 48;
   localparam int STEPS_OUT_W = 21;
   localparam int X_W         = 34;
   localparam int K_W         = 15;

   localparam int DIV_NW      = 61;
   localparam int DIV_DW      = 31;
   localparam int DIV_CNT_W   = $clog2(DIV_NW + 1);

   localparam logic [31:0] SEED_BASE  = 32'd123456789;
   localparam logic [47:0] PM_MULT    = 48'd16807;
   localparam logic [47:0] PM_MOD     = 48'd2147483647;
   localparam logic [32:0] PM_RECIP   = 33'd4405860029;   // ceil(2^49 / 127773)
   localparam logic [31:0] SEED_HALF  = 32'h4000_0000;
   localparam logic [63:0] ONE_Q32    = 64'h0000_0001_0000_0000;
   localparam logic [63:0] SAT_CAP    = 64'h4000_0000_0000_0000;
   localparam logic [31:0] W_ONE      = 32'h4000_0000;
   localparam logic [60:0] INV_NUM    = 61'h1000_0000_0000_0000;

   localparam logic [30:0] RST_A      = 31'd536870912;
   localparam logic [31:0] RST_H      = 32'd429497;
   localparam logic [30:0] RST_STEP   = 31'd2684355;
   localparam logic [20:0] RST_N      = 21'd1000;

   typedef enum logic [1:0] {
      CSR_A    = 2'd0,
      CSR_H    = 2'd1,
      CSR_STEP = 2'd2,
      CSR_N    = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      MOP_INVA2 = 3'd0,
      MOP_RX    = 3'd1,
      MOP_R2    = 3'd2,
      MOP_V     = 3'd3,
      MOP_G     = 3'd4,
      MOP_WE    = 3'd5,
      MOP_D1    = 3'd6,
      MOP_D2    = 3'd7
   } mop_type;

   typedef enum logic [1:0] {
      SH_28 = 2'd0,
      SH_32 = 2'd1,
      SH_33 = 2'd2
   } sh_type;

   typedef struct packed {
      logic [A_W-1:0]      a;
      logic [H_W-1:0]      h;
      logic [STEPSZ_W-1:0] step;
      logic [N_W-1:0]      n;
   } cfg_type;

   typedef struct packed {
      logic    load;
      logic    div_go;
      logic    div_inv;
      logic    seed_init;
      logic    seed_k;
      logic    seed_upd;
      logic    move;
      logic    copy_g;
      logic    set_timed;
      logic    mul_go;
      mop_type mop;
      logic    deliver;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic outside;
      logic max_hit;
   } sts_type;

endpackage

[rtl/core/fkw_if.sv]
// Request and response channel interfaces with valid/ready handshake.
// Depends on fkw_pkg for field widths.
interface fkw_req_if;
   logic                              valid;
   logic                              ready;
   logic [fkw_pkg::PI_W-1:0]          point_index;
   logic signed [fkw_pkg::XIN_W-1:0]  start_x;
   logic [fkw_pkg::T_W-1:0]           trial_number;

   modport source (output valid, point_index, start_x, trial_number, input ready);
   modport sink   (input valid, point_index, start_x, trial_number, output ready);
endinterface

interface fkw_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [fkw_pkg::PI_W-1:0]           point_out;
   logic [fkw_pkg::WGT_W-1:0]          trial_weight;
   logic [fkw_pkg::TOT_W-1:0]          point_total;
   logic [fkw_pkg::STEPS_OUT_W-1:0]    steps_taken;
   logic                               timed_out;

   modport source (output valid, point_out, trial_weight, point_total, steps_taken, timed_out,
                   input ready);
   modport sink   (input valid, point_out, trial_weight, point_total, steps_taken, timed_out,
                   output ready);
endinterface

[rtl/core/feynman_kac_walk_trial_top.sv]
// Top level of the 1-D random-walk trial block: configuration registers on an
// APB-style port, controller and datapath. Depends on fkw_pkg, fkw_if, fkw_ctrl, fkw_dp.
//
// Usage:
//   req carries one trial (point_index, start_x, trial_number); rsp returns one
//   result per trial (point_out, trial_weight, point_total, steps_taken, timed_out).
//   Both are valid/ready channels; a request is taken at an edge with both high.
//   Registers sit at byte addresses 0, 4, 8, 12 (half width a, time step h, walk
//   step, trials per point); the user must write them only while the block is idle,
//   which the block itself does not enforce.
// Operation:
//   One trial at a time. Setup is two divisions (trial mod N, 2^60/a) and five
//   multiplies. Each walk step is four control states plus seven multiplies on
//   the shared multiplier. A new request is taken as soon as the previous
//   result sits in the response register, even if the receiver has not yet
//   taken it; a finished trial then waits until that register frees up.
// Reset:
//   Synchronous, active high; restores register defaults and clears all
//   per-point accumulators.
module feynman_kac_walk_trial_top (
   input  logic        clock,
   input  logic        reset,
   fkw_req_if.sink     req,
   fkw_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [fkw_pkg::A_W-1:0]      a_ff;
   logic [fkw_pkg::H_W-1:0]      h_ff;
   logic [fkw_pkg::STEPSZ_W-1:0] step_ff;
   logic [fkw_pkg::N_W-1:0]      n_ff;
   fkw_pkg::csr_idx_type         csr_idx;
   logic                         csr_wr;
   fkw_pkg::cfg_type             cfg;
   fkw_pkg::cmd_type             cmd;
   fkw_pkg::sts_type             sts;

   assign csr_idx    = fkw_pkg::csr_idx_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff    <= fkw_pkg::RST_A;
         h_ff    <= fkw_pkg::RST_H;
         step_ff <= fkw_pkg::RST_STEP;
         n_ff    <= fkw_pkg::RST_N;
      end else if (csr_wr) begin
         unique case (csr_idx)
            fkw_pkg::CSR_A:    a_ff    <= csr_pwdata[fkw_pkg::A_W-1:0];
            fkw_pkg::CSR_H:    h_ff    <= csr_pwdata[fkw_pkg::H_W-1:0];
            fkw_pkg::CSR_STEP: step_ff <= csr_pwdata[fkw_pkg::STEPSZ_W-1:0];
            fkw_pkg::CSR_N:    n_ff    <= csr_pwdata[fkw_pkg::N_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         fkw_pkg::CSR_A:    csr_prdata = 32'(a_ff);
         fkw_pkg::CSR_H:    csr_prdata = h_ff;
         fkw_pkg::CSR_STEP: csr_prdata = 32'(step_ff);
         fkw_pkg::CSR_N:    csr_prdata = 32'(n_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.a    = a_ff;
   assign cfg.h    = h_ff;
   assign cfg.step = step_ff;
   assign cfg.n    = n_ff;

   fkw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fkw_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .req_point_index  (req.point_index),
      .req_start_x      (req.start_x),
      .req_trial_number (req.trial_number),
      .rsp_point_out    (rsp.point_out),
      .rsp_trial_weight (rsp.trial_weight),
      .rsp_point_total  (rsp.point_total),
      .rsp_steps_taken  (rsp.steps_taken),
      .rsp_timed_out    (rsp.timed_out)
   );

endmodule

[rtl/core/fkw_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on fkw_pkg for operand widths.
module fkw_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fkw_pkg::DIV_NW-1:0]   dividend,
   input  logic [fkw_pkg::DIV_DW-1:0]   divisor,
   output logic                         done,
   output logic [fkw_pkg::DIV_NW-1:0]   quotient,
   output logic [fkw_pkg::DIV_DW-1:0]   remainder
);

   logic [fkw_pkg::DIV_NW-1:0]    q_ff, q_in;
   logic [fkw_pkg::DIV_DW-1:0]    r_ff, r_in;
   logic [fkw_pkg::DIV_DW-1:0]    d_ff, d_in;
   logic [fkw_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [fkw_pkg::DIV_DW:0]      shifted;
   logic [fkw_pkg::DIV_DW+1:0]    diff;

   always_comb begin
      shifted = {r_ff, q_ff[fkw_pkg::DIV_NW-1]};
      diff    = {1'b0, shifted} - {2'b00, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = fkw_pkg::DIV_CNT_W'(fkw_pkg::DIV_NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[fkw_pkg::DIV_DW+1]) begin
            r_in = diff[fkw_pkg::DIV_DW-1:0];
            q_in = {q_ff[fkw_pkg::DIV_NW-2:0], 1'b1};
         end else begin
            r_in = shifted[fkw_pkg::DIV_DW-1:0];
            q_in = {q_ff[fkw_pkg::DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == fkw_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

[rtl/core/fkw_mul.sv]
// Shared 64x64 multiplier built from four 32x32 partial products, one per cycle,
// with a 128-bit accumulator, right shift and saturation at 2^62. Depends on fkw_pkg.
module fkw_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                accum,
   input  fkw_pkg::sh_type     shift,
   input  logic [63:0]         op_a,
   input  logic [63:0]         op_b,
   output logic                done,
   output logic [63:0]         result
);

   logic [63:0]     a_ff, a_in;
   logic [63:0]     b_ff, b_in;
   logic [127:0]    acc_ff, acc_in;
   logic [63:0]     pp_ff, pp_in;
   logic [2:0]      phase_ff, phase_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   fkw_pkg::sh_type sh_ff, sh_in;
   logic [31:0]     mx, my;
   logic [6:0]      shamt;
   logic [127:0]    q;

   always_comb begin
      case (phase_ff)
         3'd0:    begin mx = a_ff[31:0];  my = b_ff[31:0];  end
         3'd1:    begin mx = a_ff[31:0];  my = b_ff[63:32]; end
         3'd2:    begin mx = a_ff[63:32]; my = b_ff[31:0];  end
         default: begin mx = a_ff[63:32]; my = b_ff[63:32]; end
      endcase
      pp_in = 64'(mx) * 64'(my);
      case (phase_ff)
         3'd1:    shamt = 7'd0;
         3'd4:    shamt = 7'd64;
         default: shamt = 7'd32;
      endcase
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in     = op_a;
         b_in     = op_b;
         sh_in    = shift;
         phase_in = '0;
         busy_in  = 1'b1;
         if (!accum) begin
            acc_in = '0;
         end
      end else if (busy_ff) begin
         // add the product registered in the previous phase
         if (phase_ff != 3'd0) begin
            acc_in = acc_ff + (128'(pp_ff) << shamt);
         end
         phase_in = phase_ff + 3'd1;
         if (phase_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      case (sh_ff)
         fkw_pkg::SH_28: q = acc_ff >> 28;
         fkw_pkg::SH_32: q = acc_ff >> 32;
         fkw_pkg::SH_33: q = acc_ff >> 33;
         default:        q = acc_ff >> 32;
      endcase
      if ((|q[127:63]) || (q[62] && (|q[61:0]))) begin
         result = fkw_pkg::SAT_CAP;
      end else begin
         result = q[63:0];
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      sh_ff    <= sh_in;
      acc_ff   <= acc_in;
      pp_ff    <= pp_in;
      phase_ff <= phase_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;

endmodule

[rtl/core/fkw_dp.sv]
// Datapath: walk registers, seed generator, weight update, per-point accumulators
// and the response register. Uses fkw_div and fkw_mul; commands come from fkw_ctrl.
module fkw_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  fkw_pkg::cfg_type                  cfg,
   input  fkw_pkg::cmd_type                  cmd,
   output fkw_pkg::sts_type                  sts,
   input  logic [fkw_pkg::PI_W-1:0]          req_point_index,
   input  logic signed [fkw_pkg::XIN_W-1:0]  req_start_x,
   input  logic [fkw_pkg::T_W-1:0]           req_trial_number,
   output logic [fkw_pkg::PI_W-1:0]          rsp_point_out,
   output logic [fkw_pkg::WGT_W-1:0]         rsp_trial_weight,
   output logic [fkw_pkg::TOT_W-1:0]         rsp_point_total,
   output logic [fkw_pkg::STEPS_OUT_W-1:0]   rsp_steps_taken,
   output logic                              rsp_timed_out
);

   logic [fkw_pkg::PI_W-1:0]        pi_ff;
   logic [fkw_pkg::X_W-1:0]         x_ff, x_in;
   logic [fkw_pkg::T_W-1:0]         t_ff;
   logic [fkw_pkg::N_W-1:0]         modv_ff;
   logic [31:0]                     seed_ff, seed_in;
   logic [fkw_pkg::K_W-1:0]         k_ff, k_in;
   logic [63:0]                     inva_ff, inva2_ff, tmp_ff;
   logic [32:0]                     gs_ff, gh_ff;
   logic [31:0]                     we_ff, w_ff;
   logic [fkw_pkg::STEP_W-1:0]      steps_ff;
   logic                            timed_ff;
   logic [fkw_pkg::TOT_W-1:0]       acc_ff [fkw_pkg::ACC_DEPTH];

   logic [fkw_pkg::PI_W-1:0]        out_point_ff;
   logic [fkw_pkg::WGT_W-1:0]       out_weight_ff;
   logic [fkw_pkg::TOT_W-1:0]       out_total_ff;
   logic [fkw_pkg::STEPS_OUT_W-1:0] out_steps_ff;
   logic                            out_timed_ff;

   logic                            div_done;
   logic [fkw_pkg::DIV_NW-1:0]      div_q;
   logic [fkw_pkg::DIV_DW-1:0]      div_r;
   logic [fkw_pkg::DIV_NW-1:0]      div_num;
   logic [fkw_pkg::DIV_DW-1:0]      div_den;

   logic                            mul_done;
   logic [63:0]                     mul_res, mul_a, mul_b;
   logic                            mul_acc;
   fkw_pkg::sh_type                 mul_sh;

   logic [fkw_pkg::X_W-1:0]         ax;
   logic [34:0]                     pit;
   logic [31:0]                     mag;
   logic [64:0]                     kprod;
   logic [47:0]                     pmul, km, snew;
   logic [fkw_pkg::X_W-1:0]         step_ext;
   logic [fkw_pkg::ACC_IDX_W-1:0]   acc_idx;
   logic                            pi_ok;
   logic [fkw_pkg::TOT_W:0]         sum;
   logic [fkw_pkg::TOT_W-1:0]       sum_sat;

   // ---------------------------------------------------------------- divider
   always_comb begin
      if (cmd.div_inv) begin
         div_num = fkw_pkg::INV_NUM;
         div_den = cfg.a;
      end else begin
         div_num = fkw_pkg::DIV_NW'(t_ff);
         div_den = (cfg.n == '0) ? fkw_pkg::DIV_DW'(1) : fkw_pkg::DIV_DW'(cfg.n);
      end
   end

   fkw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_go),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // ---------------------------------------------------------------- multiplier
   assign ax = x_ff[fkw_pkg::X_W-1] ? (~x_ff + 1'b1) : x_ff;

   always_comb begin
      mul_acc = 1'b0;
      mul_sh  = fkw_pkg::SH_32;
      case (cmd.mop)
         fkw_pkg::MOP_INVA2: begin mul_a = inva_ff;  mul_b = inva_ff; end
         fkw_pkg::MOP_RX: begin
            mul_a  = 64'(ax);
            mul_b  = inva_ff;
            mul_sh = fkw_pkg::SH_28;
         end
         fkw_pkg::MOP_R2: begin mul_a = tmp_ff; mul_b = tmp_ff; end
         fkw_pkg::MOP_V: begin
            mul_a = (tmp_ff << 1) + fkw_pkg::ONE_Q32;
            mul_b = inva2_ff;
         end
         fkw_pkg::MOP_G:  begin mul_a = 64'(cfg.h); mul_b = tmp_ff; end
         fkw_pkg::MOP_WE: begin mul_a = fkw_pkg::ONE_Q32 - 64'(gs_ff); mul_b = 64'(w_ff); end
         fkw_pkg::MOP_D1: begin
            mul_a  = 64'(gh_ff);
            mul_b  = 64'(we_ff);
            mul_sh = fkw_pkg::SH_33;
         end
         fkw_pkg::MOP_D2: begin
            mul_a   = 64'(gs_ff);
            mul_b   = 64'(w_ff);
            mul_sh  = fkw_pkg::SH_33;
            mul_acc = 1'b1;
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   fkw_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_go),
      .accum  (mul_acc),
      .shift  (mul_sh),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   // ---------------------------------------------------------------- seed and walk
   always_comb begin
      pit      = 35'(pi_ff) * 35'(t_ff);
      mag      = seed_ff[31] ? (~seed_ff + 1'b1) : seed_ff;
      kprod    = 65'(mag) * 65'(fkw_pkg::PM_RECIP);
      k_in     = kprod[63:49];
      pmul     = {{16{seed_ff[31]}}, seed_ff} * fkw_pkg::PM_MULT;
      km       = (48'(k_ff) << 31) - 48'(k_ff);
      snew     = seed_ff[31] ? (pmul + km) : (pmul - km);
      if (snew[47]) begin
         snew = snew + fkw_pkg::PM_MOD;
      end
      if (cmd.seed_init) begin
         seed_in = fkw_pkg::SEED_BASE + pit[31:0] + 32'(modv_ff);
      end else begin
         seed_in = snew[31:0];
      end
      step_ext = fkw_pkg::X_W'(cfg.step);
      // step down when the new seed is below 2^30 (negative seeds included)
      if ($signed(seed_ff) < $signed(fkw_pkg::SEED_HALF)) begin
         x_in = x_ff - step_ext;
      end else begin
         x_in = x_ff + step_ext;
      end
   end

   // ---------------------------------------------------------------- accumulator
   always_comb begin
      pi_ok   = (int'(pi_ff) <= fkw_pkg::NUM_POINTS);
      acc_idx = fkw_pkg::ACC_IDX_W'(pi_ff);
      sum     = {1'b0, acc_ff[acc_idx]} + (fkw_pkg::TOT_W + 1)'(w_ff);
      sum_sat = sum[fkw_pkg::TOT_W] ? '1 : sum[fkw_pkg::TOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pi_ff    <= req_point_index;
         x_ff     <= fkw_pkg::X_W'(req_start_x);
         t_ff     <= req_trial_number;
         w_ff     <= fkw_pkg::W_ONE;
         steps_ff <= '0;
         timed_ff <= 1'b0;
      end else begin
         if (cmd.move) begin
            x_ff     <= x_in;
            steps_ff <= steps_ff + 1'b1;
         end
         if (cmd.set_timed) begin
            timed_ff <= 1'b1;
         end
         if (mul_done && (cmd.mop == fkw_pkg::MOP_D2)) begin
            w_ff <= w_ff - mul_res[31:0];
         end
      end
      if (div_done) begin
         if (cmd.div_inv) begin
            inva_ff <= 64'(div_q);
         end else begin
            modv_ff <= div_r[fkw_pkg::N_W-1:0];
         end
      end
      if (cmd.seed_init || cmd.seed_upd) begin
         seed_ff <= seed_in;
      end
      if (cmd.seed_k) begin
         k_ff <= k_in;
      end
      if (cmd.copy_g) begin
         gs_ff <= gh_ff;
      end
      if (mul_done) begin
         case (cmd.mop)
            fkw_pkg::MOP_INVA2: inva2_ff <= mul_res;
            fkw_pkg::MOP_RX,
            fkw_pkg::MOP_R2,
            fkw_pkg::MOP_V:     tmp_ff <= mul_res;
            fkw_pkg::MOP_G: begin
               gh_ff <= (mul_res > fkw_pkg::ONE_Q32) ? fkw_pkg::ONE_Q32[32:0] : mul_res[32:0];
            end
            fkw_pkg::MOP_WE:    we_ff <= mul_res[31:0];
            default: ;
         endcase
      end
      if (cmd.deliver) begin
         out_point_ff  <= pi_ff;
         out_weight_ff <= w_ff;
         out_steps_ff  <= fkw_pkg::STEPS_OUT_W'(steps_ff);
         out_timed_ff  <= timed_ff;
         out_total_ff  <= pi_ok ? sum_sat : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fkw_pkg::ACC_DEPTH; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (cmd.deliver && pi_ok) begin
         acc_ff[acc_idx] <= sum_sat;
      end
   end

   assign sts.div_done = div_done;
   assign sts.mul_done = mul_done;
   assign sts.outside  = (ax >= fkw_pkg::X_W'(cfg.a));
   assign sts.max_hit  = (32'(steps_ff) >= 32'(fkw_pkg::MAX_STEPS));

   assign rsp_point_out    = out_point_ff;
   assign rsp_trial_weight = out_weight_ff;
   assign rsp_point_total  = out_total_ff;
   assign rsp_steps_taken  = out_steps_ff;
   assign rsp_timed_out    = out_timed_ff;

endmodule

[rtl/core/fkw_ctrl.sv]
// Controller state machine: sequences setup divisions, the multiply chain of
// each walk step, the exit checks and result delivery. Depends on fkw_pkg.
module fkw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  fkw_pkg::sts_type sts,
   output fkw_pkg::cmd_type cmd
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_MOD   = 12'b0000_0000_0010,
      S_MODW  = 12'b0000_0000_0100,
      S_INV   = 12'b0000_0000_1000,
      S_INVW  = 12'b0000_0001_0000,
      S_MUL   = 12'b0000_0010_0000,
      S_MULW  = 12'b0000_0100_0000,
      S_CHECK = 12'b0000_1000_0000,
      S_SEEDK = 12'b0001_0000_0000,
      S_SEEDU = 12'b0010_0000_0000,
      S_MOVE  = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   fkw_pkg::mop_type mop_ff, mop_in;
   logic             walk_ff, walk_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      mop_in    = mop_ff;
      walk_in   = walk_ff;
      cmd       = '0;
      cmd.mop   = mop_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.div_go = 1'b1;
            state_in   = S_MODW;
         end
         S_MODW: begin
            if (sts.div_done) begin
               state_in = S_INV;
            end
         end
         S_INV: begin
            cmd.div_go    = 1'b1;
            cmd.div_inv   = 1'b1;
            cmd.seed_init = 1'b1;
            state_in      = S_INVW;
         end
         S_INVW: begin
            cmd.div_inv = 1'b1;
            if (sts.div_done) begin
               mop_in   = fkw_pkg::MOP_INVA2;
               walk_in  = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = S_MULW;
         end
         S_MULW: begin
            if (sts.mul_done) begin
               state_in = S_MUL;
               case (mop_ff)
                  fkw_pkg::MOP_INVA2: mop_in = fkw_pkg::MOP_RX;
                  fkw_pkg::MOP_RX:    mop_in = fkw_pkg::MOP_R2;
                  fkw_pkg::MOP_R2:    mop_in = fkw_pkg::MOP_V;
                  fkw_pkg::MOP_V:     mop_in = fkw_pkg::MOP_G;
                  fkw_pkg::MOP_G: begin
                     // the start point needs only its potential, no weight update
                     if (walk_ff) begin
                        mop_in = fkw_pkg::MOP_WE;
                     end else begin
                        state_in = S_CHECK;
                     end
                  end
                  fkw_pkg::MOP_WE:    mop_in = fkw_pkg::MOP_D1;
                  fkw_pkg::MOP_D1:    mop_in = fkw_pkg::MOP_D2;
                  default:            state_in = S_CHECK;
               endcase
            end
         end
         S_CHECK: begin
            cmd.copy_g = 1'b1;
            if (sts.outside) begin
               state_in = S_DONE;
            end else if (sts.max_hit) begin
               cmd.set_timed = 1'b1;
               state_in      = S_DONE;
            end else begin
               state_in = S_SEEDK;
            end
         end
         S_SEEDK: begin
            cmd.seed_k = 1'b1;
            state_in   = S_SEEDU;
         end
         S_SEEDU: begin
            cmd.seed_upd = 1'b1;
            state_in     = S_MOVE;
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            walk_in  = 1'b1;
            mop_in   = fkw_pkg::MOP_RX;
            state_in = S_MUL;
         end
         S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.deliver = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mop_ff <= mop_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         walk_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
